>>> rtl/swe_pkg.sv
// Shared constants and a rounding helper function for the stereo width expander.
// No dependencies; swe_root, swe_core and the top level refer to it by scoped names.
package swe_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int INV_SQRT2_Q24   = 11863283;
    localparam int MUL_B_W         = 28;
    localparam int RND_W           = 72;
    localparam int SQ_W            = 56;
    localparam int COMP_W          = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [14:0]       LOW_GAIN_RST  = 15'd16384;
    localparam logic [14:0]       HIGH_GAIN_RST = 15'd16384;
    localparam logic [15:0]       SPLIT_RST     = 16'd1526;
    localparam logic [COMP_W-1:0] COMP_ONE      = 17'd65536;
    localparam logic [COMP_W-1:0] COMP_MIN      = 17'd47186;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_GAIN    = 2'd0,
        REG_HIGH_GAIN   = 2'd1,
        REG_SPLIT_COEFF = 2'd2
    } t_cfg_idx;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [RND_W-1:0] rnd_shr(
        input logic signed [RND_W-1:0] v,
        input int                      sh
    );
        logic signed [RND_W-1:0] bias;
        bias = '0;
        bias[sh-1] = 1'b1;
        return (v + bias) >>> sh;
    endfunction

endpackage

>>> rtl/swe_if.sv
// Valid/ready stream interfaces for stereo pairs into and out of the block.
// Depends on nothing.
interface swe_in_if #(parameter int W = 24) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_in;
    logic signed [W-1:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface swe_out_if #(parameter int W = 24) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_out;
    logic signed [W-1:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/swe_mul.sv
// Shared signed multiplier with registered product.
// Depends on nothing.
module swe_mul #(
    parameter int AW = 36,
    parameter int BW = 28
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    logic signed [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/swe_root.sv
// Loudness factor unit: normalize, restoring divide, bit-pair square root.
// Depends on swe_pkg.
module swe_root (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [swe_pkg::SQ_W-1:0]     i_num,
    input  logic [swe_pkg::SQ_W-1:0]     i_den,
    output logic                         o_done,
    output logic [swe_pkg::COMP_W-1:0]   o_c
);

    localparam int NW = swe_pkg::SQ_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_DIV, ST_SQRT, ST_FIN
    } t_state;

    t_state           r_state;
    logic [NW-1:0]    r_num, r_den;
    logic [31:0]      r_rem;
    logic [32:0]      r_q;
    logic [33:0]      r_res, r_bit;
    logic [4:0]       r_cnt;
    logic [32:0]      w_rem2;
    logic [34:0]      w_t;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_t    = 35'(r_res) + 35'(r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_num <= i_num;
                        r_den <= i_den;
                        if (i_den == '0 || i_num >= i_den) begin
                            r_res   <= 34'(swe_pkg::COMP_ONE);
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (r_den[NW-1:31] != '0) begin
                        r_den <= r_den >> 1;
                        r_num <= r_num >> 1;
                    end else begin
                        if (r_num >= r_den) begin
                            r_rem <= 32'(r_num - r_den);
                            r_q   <= 33'd1;
                        end else begin
                            r_rem <= 32'(r_num);
                            r_q   <= 33'd0;
                        end
                        r_cnt   <= 5'd31;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_rem2 >= 33'(r_den)) begin
                        r_rem <= 32'(w_rem2 - 33'(r_den));
                        r_q   <= {r_q[31:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[31:0];
                        r_q   <= {r_q[31:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_res   <= '0;
                        r_bit   <= 34'd1 << 32;
                        r_cnt   <= 5'd16;
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                ST_SQRT: begin
                    if (35'(r_q) >= w_t) begin
                        r_q   <= 33'(35'(r_q) - w_t);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == ST_FIN);
    assign o_c    = (r_res < 34'(swe_pkg::COMP_MIN)) ? swe_pkg::COMP_MIN
                                                      : r_res[swe_pkg::COMP_W-1:0];

endmodule

>>> rtl/swe_core.sv
// Sequencer and datapath registers: mid/side, split filters, gains, loudness factor, output stage.
// Depends on swe_pkg, swe_mul and swe_root.
module swe_core #(
    parameter int W = swe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [14:0]         i_low_gain,
    input  logic [14:0]         i_high_gain,
    input  logic [15:0]         i_split_coeff,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [W-1:0] i_left_in,
    input  logic signed [W-1:0] i_right_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [W-1:0] o_left_out,
    output logic signed [W-1:0] o_right_out
);

    localparam int F   = (W < 31) ? 31 - W : 0;
    localparam int SQD = W + F - 24;
    localparam int ZW  = W + F + 1;
    localparam int AW  = ZW + 4;
    localparam int BW  = swe_pkg::MUL_B_W;
    localparam int PW  = AW + BW;
    localparam int RW  = swe_pkg::RND_W;
    localparam int NW  = swe_pkg::SQ_W;
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [BW-1:0] C_SQ2  = BW'(swe_pkg::INV_SQRT2_Q24);

    typedef enum logic [4:0] {
        ST_IDLE, ST_M_ISS, ST_M_CAP, ST_S_ISS, ST_S_CAP, ST_Z1_ISS, ST_Z1_CAP,
        ST_Z2_ISS, ST_Z2_CAP, ST_GL_ISS, ST_GL_CAP, ST_GH_ISS, ST_GH_CAP,
        ST_MD_ISS, ST_MD_CAP, ST_SD_ISS, ST_SD_CAP, ST_BD_ISS, ST_BD_CAP,
        ST_ROOT_GO, ST_ROOT_WAIT, ST_BC_ISS, ST_BC_CAP, ST_L_ISS, ST_L_CAP,
        ST_R_ISS, ST_R_CAP
    } t_state;

    t_state                r_state;
    logic signed [W-1:0]   r_l, r_r, r_lres, r_left_out, r_right_out;
    logic signed [ZW-1:0]  r_mf, r_sf, r_z1, r_z2;
    logic signed [PW-1:0]  r_acc;
    logic signed [AW-1:0]  r_boost, r_bc;
    logic [NW-1:0]         r_num, r_den;
    logic [swe_pkg::COMP_W-1:0] r_c;
    logic                  r_ovalid;

    logic                  w_en;
    logic signed [AW-1:0]  w_a;
    logic signed [BW-1:0]  w_b;
    logic signed [PW-1:0]  w_p;
    logic signed [RW-1:0]  w_pr;
    logic signed [BW-1:0]  w_md, w_sd, w_bd;
    logic                  w_root_done;
    logic [swe_pkg::COMP_W-1:0] w_root_c;
    logic                  w_out_free;

    function automatic logic signed [W-1:0] sat(input logic signed [RW-1:0] v);
        if (v > SAT_HI) begin
            return W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return W'(SAT_LO);
        end
        return W'(v);
    endfunction

    assign w_pr = RW'(w_p);
    assign w_md = BW'(swe_pkg::rnd_shr(RW'(r_mf), SQD));
    assign w_sd = BW'(swe_pkg::rnd_shr(RW'(r_sf), SQD));
    assign w_bd = BW'(swe_pkg::rnd_shr(RW'(r_boost), SQD));
    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        w_en = 1'b1;
        w_a  = '0;
        w_b  = C_SQ2;
        unique case (r_state)
            ST_M_ISS:  w_a = AW'(r_l) + AW'(r_r);
            ST_S_ISS:  w_a = AW'(r_l) - AW'(r_r);
            ST_Z1_ISS: begin
                w_a = AW'(r_sf) - AW'(r_z1);
                w_b = BW'(i_split_coeff);
            end
            ST_Z2_ISS: begin
                w_a = AW'(r_z1) - AW'(r_z2);
                w_b = BW'(i_split_coeff);
            end
            ST_GL_ISS: begin
                w_a = AW'(r_z2);
                w_b = BW'(i_low_gain);
            end
            ST_GH_ISS: begin
                w_a = AW'(r_sf) - AW'(r_z2);
                w_b = BW'(i_high_gain);
            end
            ST_MD_ISS: begin
                w_a = AW'(w_md);
                w_b = w_md;
            end
            ST_SD_ISS: begin
                w_a = AW'(w_sd);
                w_b = w_sd;
            end
            ST_BD_ISS: begin
                w_a = AW'(w_bd);
                w_b = w_bd;
            end
            ST_BC_ISS: begin
                w_a = r_boost;
                w_b = BW'(r_c);
            end
            ST_L_ISS:  w_a = AW'(r_mf) + r_bc;
            ST_R_ISS:  w_a = AW'(r_mf) - r_bc;
            default:   w_en = 1'b0;
        endcase
    end

    swe_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    swe_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ROOT_GO),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_root_done),
        .o_c     (w_root_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_z1     <= '0;
            r_z2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_out_ready && r_state != ST_R_CAP) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_l     <= i_left_in;
                        r_r     <= i_right_in;
                        r_state <= ST_M_ISS;
                    end
                end
                ST_M_ISS:  r_state <= ST_M_CAP;
                ST_M_CAP: begin
                    r_mf    <= ZW'(swe_pkg::rnd_shr(w_pr, 24 - F));
                    r_state <= ST_S_ISS;
                end
                ST_S_ISS:  r_state <= ST_S_CAP;
                ST_S_CAP: begin
                    r_sf    <= ZW'(swe_pkg::rnd_shr(w_pr, 24 - F));
                    r_state <= ST_Z1_ISS;
                end
                ST_Z1_ISS: r_state <= ST_Z1_CAP;
                ST_Z1_CAP: begin
                    r_z1    <= r_z1 + ZW'(swe_pkg::rnd_shr(w_pr, 16));
                    r_state <= ST_Z2_ISS;
                end
                ST_Z2_ISS: r_state <= ST_Z2_CAP;
                ST_Z2_CAP: begin
                    r_z2    <= r_z2 + ZW'(swe_pkg::rnd_shr(w_pr, 16));
                    r_state <= ST_GL_ISS;
                end
                ST_GL_ISS: r_state <= ST_GL_CAP;
                ST_GL_CAP: begin
                    r_acc   <= w_p;
                    r_state <= ST_GH_ISS;
                end
                ST_GH_ISS: r_state <= ST_GH_CAP;
                ST_GH_CAP: begin
                    r_boost <= AW'(swe_pkg::rnd_shr(RW'(r_acc) + w_pr, 14));
                    r_state <= ST_MD_ISS;
                end
                ST_MD_ISS: r_state <= ST_MD_CAP;
                ST_MD_CAP: begin
                    r_num   <= NW'(w_p);
                    r_den   <= NW'(w_p);
                    r_state <= ST_SD_ISS;
                end
                ST_SD_ISS: r_state <= ST_SD_CAP;
                ST_SD_CAP: begin
                    r_num   <= r_num + NW'(w_p);
                    r_state <= ST_BD_ISS;
                end
                ST_BD_ISS: r_state <= ST_BD_CAP;
                ST_BD_CAP: begin
                    r_den   <= r_den + NW'(w_p);
                    r_state <= ST_ROOT_GO;
                end
                ST_ROOT_GO: r_state <= ST_ROOT_WAIT;
                ST_ROOT_WAIT: begin
                    if (w_root_done) begin
                        r_c     <= w_root_c;
                        r_state <= ST_BC_ISS;
                    end
                end
                ST_BC_ISS: r_state <= ST_BC_CAP;
                ST_BC_CAP: begin
                    r_bc    <= AW'(swe_pkg::rnd_shr(w_pr, 16));
                    r_state <= ST_L_ISS;
                end
                ST_L_ISS:  r_state <= ST_L_CAP;
                ST_L_CAP: begin
                    r_lres  <= sat(swe_pkg::rnd_shr(w_pr, 24 + F));
                    r_state <= ST_R_ISS;
                end
                ST_R_ISS:  r_state <= ST_R_CAP;
                ST_R_CAP: begin
                    if (w_out_free) begin
                        r_left_out  <= r_lres;
                        r_right_out <= sat(swe_pkg::rnd_shr(w_pr, 24 + F));
                        r_ovalid    <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

>>> rtl/stereo_width_expander.sv
// Stereo width expander top level: config registers, stream ports, core.
// The root unit steps through normalize, divide, square root and finish; when the loudness
// factor is forced to one it goes straight to finish.
// One pair at a time, next pair taken the cycle after the result is registered.
// Synchronous active-low reset clears the split filter state, restores default gains.
// Depends on swe_pkg, swe_if, swe_core, swe_mul and swe_root.
module stereo_width_expander #(
    parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    swe_in_if.sink                           i_pair,
    swe_out_if.source                        o_pair
);

    logic [14:0] r_low_gain, r_high_gain;
    logic [15:0] r_split_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_gain    <= swe_pkg::LOW_GAIN_RST;
            r_high_gain   <= swe_pkg::HIGH_GAIN_RST;
            r_split_coeff <= swe_pkg::SPLIT_RST;
        end else if (i_cfg_we) begin
            unique case (swe_pkg::t_cfg_idx'(i_cfg_idx))
                swe_pkg::REG_LOW_GAIN:    r_low_gain    <= i_cfg_data[14:0];
                swe_pkg::REG_HIGH_GAIN:   r_high_gain   <= i_cfg_data[14:0];
                swe_pkg::REG_SPLIT_COEFF: r_split_coeff <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    swe_core #(.W(SAMPLE_BITS)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_low_gain    (r_low_gain),
        .i_high_gain   (r_high_gain),
        .i_split_coeff (r_split_coeff),
        .i_in_valid    (i_pair.valid),
        .o_in_ready    (i_pair.ready),
        .i_left_in     (i_pair.left_in),
        .i_right_in    (i_pair.right_in),
        .o_out_valid   (o_pair.valid),
        .i_out_ready   (o_pair.ready),
        .o_left_out    (o_pair.left_out),
        .o_right_out   (o_pair.right_out)
    );

endmodule

>>> rtl/swe_checker.sv
// Port-level checks for the stereo width expander, bound to the top level.
// Depends on stereo_width_expander.
module swe_checker #(
    parameter int W = 24
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic signed [W-1:0] i_left_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after an input transfer");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result one cycle after input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_left_out)))
        else $error("stalled output changed");

endmodule

bind stereo_width_expander swe_checker #(.W(SAMPLE_BITS)) u_swe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_pair.valid),
    .i_out_ready (o_pair.ready),
    .i_left_out  (o_pair.left_out)
);
